### src/i2cw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write transaction package
// Types, register indexes, reset values and phase codes that the I2C
// three-byte writer shares between its modules.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDRESS_BYTE  = 3'd0,
        CFG_COMMAND_CTRL  = 3'd1,
        CFG_DATA_CTRL     = 3'd2,
        CFG_HALF_PERIOD   = 3'd3,
        CFG_SETUP_TICKS   = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_ADDRESS_BYTE = 8'h78;
    localparam logic [7:0] RST_COMMAND_CTRL = 8'h00;
    localparam logic [7:0] RST_DATA_CTRL    = 8'h40;
    localparam logic [7:0] RST_HALF_PERIOD  = 8'd5;
    localparam logic [7:0] RST_SETUP_TICKS  = 8'd1;

    // Which byte of the transaction is on the wire.
    localparam logic [1:0] BYTE_ADDRESS = 2'd0;
    localparam logic [1:0] BYTE_CONTROL = 2'd1;
    localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

    // Input item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Line-level phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE        = 9'b000000001,
        PH_START_SETUP = 9'b000000010,
        PH_START_HOLD  = 9'b000000100,
        PH_BIT_LOW     = 9'b000001000,
        PH_BIT_HIGH    = 9'b000010000,
        PH_ACK_LOW     = 9'b000100000,
        PH_ACK_HIGH    = 9'b001000000,
        PH_STOP_LOW    = 9'b010000000,
        PH_STOP_HIGH   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] command_control_byte;
        logic [7:0] data_control_byte;
        logic [7:0] half_period_ticks;
        logic [7:0] setup_ticks;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic       is_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy;
        logic       done;
        logic       nack_seen;
        logic [1:0] nack_stage;
    } result_t;

    typedef struct packed {
        logic       nack;
        logic [1:0] stage;
    } error_t;

endpackage

### src/i2cw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C writer configuration registers
// Holds the five configuration registers written through the plain write
// port. Writes to indexes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module i2cw_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [i2cw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output i2cw_pkg::cfg_t                   cfg
);

    i2cw_pkg::cfg_t cfg_reg;
    i2cw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (i2cw_pkg::cfg_index_t'(cfg_index))
                i2cw_pkg::CFG_ADDRESS_BYTE: cfg_next.address_byte         = cfg_data;
                i2cw_pkg::CFG_COMMAND_CTRL: cfg_next.command_control_byte = cfg_data;
                i2cw_pkg::CFG_DATA_CTRL:    cfg_next.data_control_byte    = cfg_data;
                i2cw_pkg::CFG_HALF_PERIOD:  cfg_next.half_period_ticks    = cfg_data;
                i2cw_pkg::CFG_SETUP_TICKS:  cfg_next.setup_ticks          = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_byte         <= i2cw_pkg::RST_ADDRESS_BYTE;
            cfg_reg.command_control_byte <= i2cw_pkg::RST_COMMAND_CTRL;
            cfg_reg.data_control_byte    <= i2cw_pkg::RST_DATA_CTRL;
            cfg_reg.half_period_ticks    <= i2cw_pkg::RST_HALF_PERIOD;
            cfg_reg.setup_ticks          <= i2cw_pkg::RST_SETUP_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/i2cw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C writer line state machine
// Counts down the delay on each accepted tick, advances the start, bit,
// acknowledge and stop phases when it runs out, and forms each result.
// ----------------------------------------------------------------------------
module i2cw_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  i2cw_pkg::item_t      item,
    input  i2cw_pkg::cfg_t       cfg,
    output i2cw_pkg::result_t    res
);

    i2cw_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       bit_reg, bit_next;
    logic [1:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       delay_reg, delay_next;
    logic [7:0]       payload_reg, payload_next;
    logic             is_data_reg, is_data_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    i2cw_pkg::error_t error_reg, error_next;

    logic             done;
    logic [7:0]       ctrl_byte;
    logic [7:0]       next_byte;
    logic [7:0]       shifted;
    logic [2:0]       bit_inc;

    assign ctrl_byte = is_data_reg ? cfg.data_control_byte : cfg.command_control_byte;
    assign next_byte = (byte_reg == i2cw_pkg::BYTE_ADDRESS) ? ctrl_byte : payload_reg;
    assign shifted   = {shift_reg[6:0], 1'b0};
    assign bit_inc   = bit_reg + 3'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        payload_next = payload_reg;
        is_data_next = is_data_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        error_next   = error_reg;
        done         = 1'b0;

        if (step)
        begin
            if (item.kind == i2cw_pkg::KIND_REQUEST)
            begin
                // A request while busy is dropped without counting as a tick.
                if (phase_reg == i2cw_pkg::PH_IDLE)
                begin
                    payload_next = item.payload;
                    is_data_next = item.is_data;
                    error_next   = '0;
                    byte_next    = i2cw_pkg::BYTE_ADDRESS;
                    bit_next     = 3'd0;
                    phase_next   = i2cw_pkg::PH_START_SETUP;
                    delay_next   = cfg.setup_ticks;
                    scl_next     = 1'b1;
                    sda_next     = 1'b1;
                end
            end
            else if (phase_reg != i2cw_pkg::PH_IDLE)
            begin
                if (delay_reg > 8'd1)
                begin
                    delay_next = delay_reg - 8'd1;
                end
                else
                begin
                    delay_next = cfg.half_period_ticks;
                    case (phase_reg)
                        i2cw_pkg::PH_START_SETUP:
                        begin
                            phase_next = i2cw_pkg::PH_START_HOLD;
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                        end
                        i2cw_pkg::PH_START_HOLD:
                        begin
                            byte_next  = i2cw_pkg::BYTE_ADDRESS;
                            bit_next   = 3'd0;
                            shift_next = cfg.address_byte;
                            phase_next = i2cw_pkg::PH_BIT_LOW;
                            scl_next   = 1'b0;
                            sda_next   = cfg.address_byte[7];
                        end
                        i2cw_pkg::PH_BIT_LOW:
                        begin
                            phase_next = i2cw_pkg::PH_BIT_HIGH;
                            scl_next   = 1'b1;
                        end
                        i2cw_pkg::PH_BIT_HIGH:
                        begin
                            shift_next = shifted;
                            bit_next   = bit_inc;
                            scl_next   = 1'b0;
                            if (bit_inc == 3'd0)
                            begin
                                phase_next = i2cw_pkg::PH_ACK_LOW;
                                sda_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next = i2cw_pkg::PH_BIT_LOW;
                                sda_next   = shifted[7];
                            end
                        end
                        i2cw_pkg::PH_ACK_LOW:
                        begin
                            phase_next = i2cw_pkg::PH_ACK_HIGH;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                        i2cw_pkg::PH_ACK_HIGH:
                        begin
                            if (item.sda_in)
                            begin
                                // No acknowledge: remember the byte and stop.
                                error_next.nack  = 1'b1;
                                error_next.stage = byte_reg;
                                phase_next       = i2cw_pkg::PH_STOP_LOW;
                                scl_next         = 1'b0;
                                sda_next         = 1'b0;
                            end
                            else if (byte_reg >= i2cw_pkg::BYTE_PAYLOAD)
                            begin
                                phase_next = i2cw_pkg::PH_STOP_LOW;
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                            end
                            else
                            begin
                                byte_next  = byte_reg + 2'd1;
                                bit_next   = 3'd0;
                                shift_next = next_byte;
                                phase_next = i2cw_pkg::PH_BIT_LOW;
                                scl_next   = 1'b0;
                                sda_next   = next_byte[7];
                            end
                        end
                        i2cw_pkg::PH_STOP_LOW:
                        begin
                            phase_next = i2cw_pkg::PH_STOP_HIGH;
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                        end
                        i2cw_pkg::PH_STOP_HIGH:
                        begin
                            phase_next = i2cw_pkg::PH_IDLE;
                            delay_next = 8'd0;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            phase_next = i2cw_pkg::PH_IDLE;
                            delay_next = 8'd0;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cw_pkg::PH_IDLE;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            delay_reg   <= '0;
            payload_reg <= '0;
            is_data_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            error_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            delay_reg   <= delay_next;
            payload_reg <= payload_next;
            is_data_reg <= is_data_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            error_reg   <= error_next;
        end
    end

    always_comb
    begin
        res.scl_level  = scl_next;
        res.sda_level  = sda_next;
        res.busy       = (phase_next != i2cw_pkg::PH_IDLE);
        res.done       = done;
        res.nack_seen  = done & error_next.nack;
        res.nack_stage = (done & error_next.nack) ? error_next.stage : 2'd0;
    end

endmodule

### src/i2cw_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C writer result buffer
// Two-entry queue that holds finished results so that the input side keeps
// moving, until both entries are full, while the output side is stalled.
// ----------------------------------------------------------------------------
module i2cw_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i2cw_pkg::result_t    push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output i2cw_pkg::result_t    out_data
);

    i2cw_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid & ~out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/i2c_master_three_byte_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master three-byte writer
// Bit-level I2C master that sends address, control and payload bytes as one
// write transaction, stepped by time ticks, with a stop and error on NACK.
// ----------------------------------------------------------------------------
// Results: each result is registered in the result queue before it is
//   offered; every input transaction yields exactly one result.
// Throughput: one input transaction per cycle while the result queue has
//   room, set by the phase update in the line state machine; a two-entry
//   result queue lets input go on while one result waits at the output.
// Reset: rst_n clears the machine to idle with both lines released, empties
//   the result queue and loads the configuration reset values.
// ----------------------------------------------------------------------------
module i2c_master_three_byte_writer_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [i2cw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cw_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Input channel: a time tick or a transaction request.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [7:0]                       payload,
    input  logic                             is_data,
    input  logic                             sda_in,

    // Output channel: line levels and status after each input transaction.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             scl_level,
    output logic                             sda_level,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             nack_seen,
    output logic [1:0]                       nack_stage
);

    i2cw_pkg::cfg_t    cfg;
    i2cw_pkg::item_t   item;
    i2cw_pkg::result_t core_res;
    i2cw_pkg::result_t out_res;
    logic              buf_full;
    logic              accept;

    // An input transaction is taken whenever the result queue has room, so
    // the state machine steps once per accepted transaction.
    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    assign item.kind    = kind;
    assign item.payload = payload;
    assign item.is_data = is_data;
    assign item.sda_in  = sda_in;

    i2cw_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The core computes the next line state and the result in one pass.
    i2cw_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .item  (item),
        .cfg   (cfg),
        .res   (core_res)
    );

    // The result queue registers each result and decouples the two sides.
    i2cw_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign scl_level  = out_res.scl_level;
    assign sda_level  = out_res.sda_level;
    assign busy_res   = out_res.busy;
    assign done_res   = out_res.done;
    assign nack_seen  = out_res.nack_seen;
    assign nack_stage = out_res.nack_stage;

    // A completed transaction always leaves the machine idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done reported while still busy");

    // A NACK is only reported together with done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nack_seen) |-> done_res)
        else $error("nack reported without done");

    // When idle, both lines are released.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (scl_level && sda_level))
        else $error("line held low while idle");

    // The failed-byte code never names a fourth byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nack_stage != 2'd3))
        else $error("invalid nack stage");

endmodule
